// ----- src/hwfpd_pkg.sv -----
// Shared types, constants and codes for the haptic wall force PD controller.
`default_nettype none

package hwfpd_pkg;

    // Position table size; the index clamps to its last entry.
    localparam int POSITION_COUNT = 150;
    localparam logic [9:0] LAST_INDEX = 10'(POSITION_COUNT - 1);

    // Low-pass weights in Q0.16: 0.85 and 0.15.
    localparam int FILT_KEEP = 55706;
    localparam int FILT_TAKE = 9830;

    // Reciprocal of 5 scaled by 2^24; exact for dividends below 2^21.
    localparam int RECIP5 = 3355444;
    localparam int RECIP_SHIFT = 24;
    // The divide by 640 is a shift by 7 followed by the divide by 5.
    localparam int DIV_SHIFT = 7;

    localparam logic [14:0] TARGET_MAX = 15'h7fff;

    typedef enum logic [3:0] {
        REG_POSITION_OFFSET = 4'd0,
        REG_WALL_START      = 4'd1,
        REG_WALL_STIFFNESS  = 4'd2,
        REG_KP_WALL         = 4'd3,
        REG_KD_WALL         = 4'd4,
        REG_KP_FREE         = 4'd5,
        REG_KD_FREE         = 4'd6,
        REG_CURRENT_LIMIT   = 4'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_TARGET = 3'd0,
        MUL_KEEP   = 3'd1,
        MUL_TAKE   = 3'd2,
        MUL_KP     = 3'd3,
        MUL_KD     = 3'd4,
        MUL_RECIP  = 3'd5
    } mul_sel_t;

    typedef struct packed {
        logic [11:0]        raw_position;
        logic signed [15:0] measured_force;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] drive_current;
        logic [9:0]         position_index;
        logic               in_wall;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [11:0] position_offset;
        logic [9:0]  wall_start;
        logic [15:0] wall_stiffness;
        logic [9:0]  kp_wall;
        logic [9:0]  kd_wall;
        logic [9:0]  kp_free;
        logic [9:0]  kd_free;
        logic [14:0] current_limit;
    } cfg_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     target_load;
        logic     acc_load;
        logic     filt_load;
        logic     err_load;
        logic     sum_load;
        logic     abs_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- src/hwfpd_ctrl.sv -----
// Sequencer that steps one item through the shared-multiplier datapath.
`default_nettype none

module hwfpd_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire hwfpd_pkg::sts_t sts,
    output hwfpd_pkg::cmd_t      cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_TARGET = 12'b0000_0000_0010,
        ST_KEEP   = 12'b0000_0000_0100,
        ST_TAKE   = 12'b0000_0000_1000,
        ST_FILT   = 12'b0000_0001_0000,
        ST_ERR    = 12'b0000_0010_0000,
        ST_MULP   = 12'b0000_0100_0000,
        ST_MULD   = 12'b0000_1000_0000,
        ST_SUM    = 12'b0001_0000_0000,
        ST_ABS    = 12'b0010_0000_0000,
        ST_RECIP  = 12'b0100_0000_0000,
        ST_FINISH = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mul_sel     = hwfpd_pkg::MUL_TARGET;
        s_ready         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_TARGET;
                end
            end
            ST_TARGET: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hwfpd_pkg::MUL_TARGET;
                state_next  = ST_KEEP;
            end
            ST_KEEP: begin
                cmd.target_load = 1'b1;
                cmd.mul_en      = 1'b1;
                cmd.mul_sel     = hwfpd_pkg::MUL_KEEP;
                state_next      = ST_TAKE;
            end
            ST_TAKE: begin
                cmd.acc_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = hwfpd_pkg::MUL_TAKE;
                state_next   = ST_FILT;
            end
            ST_FILT: begin
                cmd.filt_load = 1'b1;
                state_next    = ST_ERR;
            end
            ST_ERR: begin
                cmd.err_load = 1'b1;
                state_next   = ST_MULP;
            end
            ST_MULP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hwfpd_pkg::MUL_KP;
                state_next  = ST_MULD;
            end
            ST_MULD: begin
                cmd.acc_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = hwfpd_pkg::MUL_KD;
                state_next   = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_load = 1'b1;
                state_next   = ST_ABS;
            end
            ST_ABS: begin
                cmd.abs_load = 1'b1;
                state_next   = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = hwfpd_pkg::MUL_RECIP;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold the finished value until the output register can take it.
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register is occupied");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !cmd.out_load)
        else $error("controller took a second item or finished too early");

endmodule

`default_nettype wire

// ----- src/hwfpd_datapath.sv -----
// Datapath: position clamp, filter, PD law, divide by 640 and saturation.
`default_nettype none

module hwfpd_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire hwfpd_pkg::cmd_t     cmd,
    input  wire hwfpd_pkg::cfg_t     cfg,
    input  wire hwfpd_pkg::in_item_t s_item,
    output hwfpd_pkg::sts_t          sts,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output hwfpd_pkg::out_item_t     m_item
);

    localparam int QL = hwfpd_pkg::RECIP_SHIFT;

    logic [9:0]           pos_reg;
    logic                 wall_reg;
    logic signed [15:0]   meas_reg;
    logic signed [55:0]   prod_reg;
    logic signed [48:0]   acc_reg;
    logic [14:0]          target_reg;
    logic signed [31:0]   ff_reg;
    logic signed [17:0]   prev_err_reg;
    logic signed [17:0]   err_reg;
    logic signed [17:0]   derr_reg;
    logic signed [28:0]   u_reg;
    logic [20:0]          mag_reg;
    logic                 neg_reg;
    hwfpd_pkg::out_item_t out_reg;
    logic                 m_valid_reg;

    logic signed [12:0] pos_diff;
    logic [9:0]         pos_c;
    logic               wall_c;
    logic [9:0]         ramp_step;
    logic [9:0]         kp_sel;
    logic [9:0]         kd_sel;
    logic signed [32:0] mul_a;
    logic signed [22:0] mul_b;
    logic [14:0]        target_c;
    logic signed [48:0] take_term;
    logic signed [48:0] filt_sum;
    logic signed [17:0] err_c;
    logic signed [17:0] derr_c;
    logic signed [28:0] u_c;
    logic signed [28:0] u_abs;
    logic [18:0]        quot;
    logic signed [19:0] cur_c;
    logic signed [19:0] limit_ext;
    logic signed [15:0] drive_c;
    logic               sat_c;

    // Position index: clamp raw minus offset into the table.
    always_comb begin
        pos_diff = 13'({1'b0, s_item.raw_position}) - 13'({1'b0, cfg.position_offset});
        if (pos_diff[12]) begin
            pos_c = '0;
        end else if (pos_diff[11:0] > {2'b00, hwfpd_pkg::LAST_INDEX}) begin
            pos_c = hwfpd_pkg::LAST_INDEX;
        end else begin
            pos_c = pos_diff[9:0];
        end
        wall_c = pos_c > cfg.wall_start;
    end

    assign ramp_step = pos_reg - cfg.wall_start;
    assign kp_sel    = wall_reg ? cfg.kp_wall : cfg.kp_free;
    assign kd_sel    = wall_reg ? cfg.kd_wall : cfg.kd_free;

    // One shared signed multiplier, operands chosen per step.
    always_comb begin
        case (cmd.mul_sel)
            hwfpd_pkg::MUL_TARGET: begin
                mul_a = {23'b0, ramp_step};
                mul_b = {7'b0, cfg.wall_stiffness};
            end
            hwfpd_pkg::MUL_KEEP: begin
                mul_a = 33'(ff_reg);
                mul_b = 23'(hwfpd_pkg::FILT_KEEP);
            end
            hwfpd_pkg::MUL_TAKE: begin
                mul_a = 33'(meas_reg);
                mul_b = 23'(hwfpd_pkg::FILT_TAKE);
            end
            hwfpd_pkg::MUL_KP: begin
                mul_a = 33'(err_reg);
                mul_b = {13'b0, kp_sel};
            end
            hwfpd_pkg::MUL_KD: begin
                mul_a = 33'(derr_reg);
                mul_b = {13'b0, kd_sel};
            end
            hwfpd_pkg::MUL_RECIP: begin
                mul_a = {12'b0, mag_reg};
                mul_b = 23'(hwfpd_pkg::RECIP5);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        if (!wall_reg) begin
            target_c = '0;
        end else if (|prod_reg[55:17]) begin
            target_c = hwfpd_pkg::TARGET_MAX;
        end else begin
            target_c = prod_reg[16:2];
        end

        // The take product is at most 30 bits; it enters at weight 2^16.
        take_term = {{3{prod_reg[29]}}, prod_reg[29:0], 16'b0};
        filt_sum  = acc_reg + take_term;

        err_c  = {3'b000, target_reg} - {{2{ff_reg[31]}}, ff_reg[31:16]};
        derr_c = err_c - prev_err_reg;

        u_c   = acc_reg[28:0] + prod_reg[28:0];
        u_abs = u_reg[28] ? -u_reg : u_reg;

        // Magnitude quotient, then the sign goes back on: truncation toward zero.
        quot      = prod_reg[QL+18:QL];
        cur_c     = neg_reg ? -{1'b0, quot} : {1'b0, quot};
        limit_ext = {5'b0, cfg.current_limit};
        if (cur_c > limit_ext) begin
            drive_c = 16'(limit_ext);
            sat_c   = 1'b1;
        end else if (cur_c < -20'sd32768) begin
            drive_c = -16'sd32768;
            sat_c   = 1'b1;
        end else begin
            drive_c = cur_c[15:0];
            sat_c   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pos_reg  <= pos_c;
            wall_reg <= wall_c;
            meas_reg <= s_item.measured_force;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_load) begin
            acc_reg <= prod_reg[48:0];
        end
        if (cmd.target_load) begin
            target_reg <= target_c;
        end
        if (cmd.err_load) begin
            err_reg  <= err_c;
            derr_reg <= derr_c;
        end
        if (cmd.sum_load) begin
            u_reg <= u_c;
        end
        if (cmd.abs_load) begin
            mag_reg <= u_abs[27:hwfpd_pkg::DIV_SHIFT];
            neg_reg <= u_reg[28];
        end
        if (cmd.out_load) begin
            out_reg.drive_current  <= drive_c;
            out_reg.position_index <= pos_reg;
            out_reg.in_wall        <= wall_reg;
            out_reg.saturated      <= sat_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_reg       <= '0;
            prev_err_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.filt_load) begin
                ff_reg <= filt_sum[47:16];
            end
            if (cmd.err_load) begin
                prev_err_reg <= err_c;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_item       = out_reg;

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> out_reg.position_index <= hwfpd_pkg::LAST_INDEX)
        else $error("delivered position index beyond the table");

    a_wall_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.in_wall |-> out_reg.position_index != 10'd0)
        else $error("in-wall result at index zero");

    a_free_target: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.target_load && !wall_reg |=> target_reg == 15'd0)
        else $error("nonzero target force outside the wall");

endmodule

`default_nettype wire

// ----- src/haptic_wall_force_pd_controller_core.sv -----
// Top level: configuration registers, sequencer and datapath of the wall force controller.
//
// Input items (s_valid/s_ready/s_item) carry a raw position reading and a measured
// force; each produces exactly one result item on m_valid/m_ready/m_item with the
// drive current, clamped position index, in-wall flag and saturation flag.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high and unknown indexes are ignored. Write them only while idle.
// A sequencer steps each accepted item through a
// single shared 33x23 signed multiplier (ramp, two filter products, P, D and the
// reciprocal divide by 5), and m_valid rises once the result is loaded. The sequencer
// takes the next item only after it has returned to idle from the last one.
// s_ready is high only while the sequencer is idle. A finished result sits in an
// output register; the next item is accepted while it waits, and its own result
// is held in the datapath until the receiver takes the earlier one.
// Reset (aresetn low, synchronous) restores register defaults, clears the filter
// state and the previous error, and empties the output register.
`default_nettype none

module haptic_wall_force_pd_controller_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire hwfpd_pkg::in_item_t s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output hwfpd_pkg::out_item_t     m_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [3:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);

    hwfpd_pkg::cfg_t cfg_reg;
    hwfpd_pkg::cfg_t cfg_next;
    hwfpd_pkg::cmd_t cmd;
    hwfpd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                hwfpd_pkg::REG_POSITION_OFFSET: cfg_next.position_offset = cfg_data[11:0];
                hwfpd_pkg::REG_WALL_START:      cfg_next.wall_start      = cfg_data[9:0];
                hwfpd_pkg::REG_WALL_STIFFNESS:  cfg_next.wall_stiffness  = cfg_data;
                hwfpd_pkg::REG_KP_WALL:         cfg_next.kp_wall         = cfg_data[9:0];
                hwfpd_pkg::REG_KD_WALL:         cfg_next.kd_wall         = cfg_data[9:0];
                hwfpd_pkg::REG_KP_FREE:         cfg_next.kp_free         = cfg_data[9:0];
                hwfpd_pkg::REG_KD_FREE:         cfg_next.kd_free         = cfg_data[9:0];
                hwfpd_pkg::REG_CURRENT_LIMIT:   cfg_next.current_limit   = cfg_data[14:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.position_offset <= 12'd200;
            cfg_reg.wall_start      <= 10'd130;
            cfg_reg.wall_stiffness  <= 16'd2021;
            cfg_reg.kp_wall         <= 10'd200;
            cfg_reg.kd_wall         <= 10'd5;
            cfg_reg.kp_free         <= 10'd300;
            cfg_reg.kd_free         <= 10'd50;
            cfg_reg.current_limit   <= 15'd2400;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hwfpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hwfpd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .s_item  (s_item),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

// ----- bench/haptic_wall_force_pd_controller_core_tb.sv -----
// Self-checking testbench for the haptic wall force PD controller core.
`timescale 1ns / 100ps

module haptic_wall_force_pd_controller_core_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASE_COUNT    = 9;
    localparam int PHASE_ITEMS    = 150;
    localparam int TAIL_CYCLES    = 24;
    // An index that maps to no register; writes to it must change nothing.
    localparam logic [3:0] REG_UNMAPPED = 4'd11;

    // Tracks the controller state, predicts each drive command and checks results.
    class force_loop_scoreboard;
        hwfpd_pkg::cfg_t      regs;
        int                   filt_force;
        int                   last_error;
        hwfpd_pkg::out_item_t queued[$];
        int                   mismatches;
        int                   noted;
        int                   checked;
        int                   wall_count;
        int                   clip_count;

        function new();
            regs.position_offset = 12'd200;
            regs.wall_start      = 10'd130;
            regs.wall_stiffness  = 16'd2021;
            regs.kp_wall         = 10'd200;
            regs.kd_wall         = 10'd5;
            regs.kp_free         = 10'd300;
            regs.kd_free         = 10'd50;
            regs.current_limit   = 15'd2400;
            filt_force = 0;
            last_error = 0;
            mismatches = 0;
            noted      = 0;
            checked    = 0;
            wall_count = 0;
            clip_count = 0;
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        function void write_reg(input logic [3:0] idx, input logic [15:0] data);
            case (idx)
                hwfpd_pkg::REG_POSITION_OFFSET: regs.position_offset = data[11:0];
                hwfpd_pkg::REG_WALL_START:      regs.wall_start      = data[9:0];
                hwfpd_pkg::REG_WALL_STIFFNESS:  regs.wall_stiffness  = data;
                hwfpd_pkg::REG_KP_WALL:         regs.kp_wall         = data[9:0];
                hwfpd_pkg::REG_KD_WALL:         regs.kd_wall         = data[9:0];
                hwfpd_pkg::REG_KP_FREE:         regs.kp_free         = data[9:0];
                hwfpd_pkg::REG_KD_FREE:         regs.kd_free         = data[9:0];
                hwfpd_pkg::REG_CURRENT_LIMIT:   regs.current_limit   = data[14:0];
                default: ;
            endcase
        endfunction

        function void note_input(input hwfpd_pkg::in_item_t it);
            longint               pos;
            longint               target;
            longint               acc;
            longint               err;
            longint               derr;
            longint               kp;
            longint               kd;
            longint               cur;
            logic                 wall;
            logic                 sat;
            hwfpd_pkg::out_item_t res;
            pos = longint'(it.raw_position) - longint'(regs.position_offset);
            if (pos < 0) begin
                pos = 0;
            end
            if (pos > hwfpd_pkg::POSITION_COUNT - 1) begin
                pos = hwfpd_pkg::POSITION_COUNT - 1;
            end
            wall = pos > longint'(regs.wall_start);
            target = 0;
            if (wall) begin
                target = ((pos - longint'(regs.wall_start)) * longint'(regs.wall_stiffness)) / 4;
                if (target > 32767) begin
                    target = 32767;
                end
            end
            // Low-pass state is Q16.16; the arithmetic shift floors.
            acc = longint'(filt_force) * hwfpd_pkg::FILT_KEEP
                + longint'(it.measured_force) * 65536 * hwfpd_pkg::FILT_TAKE;
            filt_force = int'(acc >>> 16);
            err = target - (longint'(filt_force) >>> 16);
            derr = err - longint'(last_error);
            last_error = int'(err);
            kp = wall ? longint'(regs.kp_wall) : longint'(regs.kp_free);
            kd = wall ? longint'(regs.kd_wall) : longint'(regs.kd_free);
            // Signed division truncates toward zero.
            cur = (kp * err + kd * derr) / 640;
            sat = 1'b0;
            if (cur > longint'(regs.current_limit)) begin
                cur = longint'(regs.current_limit);
                sat = 1'b1;
            end else if (cur < -32768) begin
                cur = -32768;
                sat = 1'b1;
            end
            res.drive_current  = 16'(cur);
            res.position_index = 10'(pos);
            res.in_wall        = wall;
            res.saturated      = sat;
            queued.push_back(res);
            noted++;
            if (wall) begin
                wall_count++;
            end
            if (sat) begin
                clip_count++;
            end
        endfunction

        task check_result(input hwfpd_pkg::out_item_t got);
            hwfpd_pkg::out_item_t want;
            if (queued.size() == 0) begin
                report($sformatf("result with nothing pending, current %0d", got.drive_current));
            end else begin
                want = queued.pop_front();
                if (got.drive_current !== want.drive_current) begin
                    report($sformatf("result %0d drive_current %0d, predicted %0d",
                                     checked, got.drive_current, want.drive_current));
                end
                if (got.position_index !== want.position_index) begin
                    report($sformatf("result %0d position_index %0d, predicted %0d",
                                     checked, got.position_index, want.position_index));
                end
                if (got.in_wall !== want.in_wall) begin
                    report($sformatf("result %0d in_wall %b, predicted %b",
                                     checked, got.in_wall, want.in_wall));
                end
                if (got.saturated !== want.saturated) begin
                    report($sformatf("result %0d saturated %b, predicted %b",
                                     checked, got.saturated, want.saturated));
                end
            end
            checked++;
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    hwfpd_pkg::in_item_t  s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    hwfpd_pkg::out_item_t m_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [3:0]           cfg_index = 4'd0;
    logic [15:0]          cfg_data  = 16'd0;

    force_loop_scoreboard sb = new();

    bit              quiet   = 1'b0;
    bit              rx_hold = 1'b0;
    hwfpd_pkg::cfg_t cur_regs;
    int              force_level = 0;
    int              burst_left  = 0;
    int              settings    = 1;

    haptic_wall_force_pd_controller_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic hwfpd_pkg::in_item_t mk_item(input int raw, input int force_val);
        hwfpd_pkg::in_item_t it;
        it.raw_position   = 12'(raw);
        it.measured_force = 16'(force_val);
        return it;
    endfunction

    function automatic hwfpd_pkg::cfg_t mk_regs(input int offset, input int wstart,
                                                input int stiff, input int kpw,
                                                input int kdw, input int kpf,
                                                input int kdf, input int limit);
        hwfpd_pkg::cfg_t c;
        c.position_offset = 12'(offset);
        c.wall_start      = 10'(wstart);
        c.wall_stiffness  = 16'(stiff);
        c.kp_wall         = 10'(kpw);
        c.kd_wall         = 10'(kdw);
        c.kp_free         = 10'(kpf);
        c.kd_free         = 10'(kdf);
        c.current_limit   = 15'(limit);
        return c;
    endfunction

    // Biased toward both ends of a register's range.
    function automatic int pick(input int hi);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return hi;
        end
        return $urandom_range(0, hi);
    endfunction

    function automatic hwfpd_pkg::cfg_t random_regs();
        int ws;
        case ($urandom_range(0, 7))
            0: ws = 0;
            1: ws = 1023;
            2: ws = hwfpd_pkg::POSITION_COUNT - 1;
            3: ws = hwfpd_pkg::POSITION_COUNT - 2;
            default: ws = $urandom_range(0, 160);
        endcase
        return mk_regs(pick(4095), ws, pick(65535), pick(1023), pick(1023),
                       pick(1023), pick(1023), pick(32767));
    endfunction

    // Position mostly sweeps the table around the offset; force comes in bursts
    // around one level so that the filter settles, with noise mixed in.
    function automatic hwfpd_pkg::in_item_t random_item();
        int raw;
        int f;
        if ($urandom_range(0, 9) == 0) begin
            raw = $urandom_range(0, 4095);
        end else begin
            raw = int'(cur_regs.position_offset) + int'($urandom_range(0, 165)) - 8;
            if (raw < 0) begin
                raw = 0;
            end
            if (raw > 4095) begin
                raw = 4095;
            end
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: force_level = -32768;
                1: force_level = 32767;
                2: force_level = int'($urandom_range(0, 65535)) - 32768;
                default: force_level = int'($urandom_range(0, 400)) - 200;
            endcase
        end
        burst_left--;
        if ($urandom_range(0, 3) == 0) begin
            f = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            f = force_level + int'($urandom_range(0, 64)) - 32;
            if (f < -32768) begin
                f = -32768;
            end
            if (f > 32767) begin
                f = 32767;
            end
        end
        return mk_item(raw, f);
    endfunction

    // Writes every register, with junk above each field's width; optionally
    // also an index with no register behind it.
    task automatic program_regs(input hwfpd_pkg::cfg_t c, input bit poke_unmapped);
        logic [3:0]  idx[9];
        logic [15:0] val[9];
        int          width[9];
        int          count;
        idx = '{hwfpd_pkg::REG_POSITION_OFFSET, hwfpd_pkg::REG_WALL_START,
                hwfpd_pkg::REG_WALL_STIFFNESS, hwfpd_pkg::REG_KP_WALL,
                hwfpd_pkg::REG_KD_WALL, hwfpd_pkg::REG_KP_FREE, hwfpd_pkg::REG_KD_FREE,
                hwfpd_pkg::REG_CURRENT_LIMIT, REG_UNMAPPED};
        val = '{16'(c.position_offset), 16'(c.wall_start), c.wall_stiffness,
                16'(c.kp_wall), 16'(c.kd_wall), 16'(c.kp_free), 16'(c.kd_free),
                16'(c.current_limit), 16'($urandom)};
        width = '{12, 10, 16, 10, 10, 10, 10, 15, 0};
        count = poke_unmapped ? 9 : 8;
        for (int k = 0; k < count; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= (width[k] >= 16) ? val[k] : ((16'($urandom) << width[k]) | val[k]);
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(cfg_index, cfg_data);
        end
        cfg_valid <= 1'b0;
        cur_regs = c;
        settings++;
    endtask

    task automatic send_item(input hwfpd_pkg::in_item_t it);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    // Always advances at least one cycle, so valid is never dropped and raised
    // in the same step.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.queued.size() > 0) @(posedge aclk);
    endtask

    task automatic send_list(input hwfpd_pkg::in_item_t items[$]);
        foreach (items[k]) begin
            send_item(items[k]);
        end
        pause_until_drained();
    endtask

    // Result side: random stalls per item, and one long hold-off when asked.
    initial begin
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_item);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, sb.queued.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        hwfpd_pkg::in_item_t items[$];
        cur_regs = sb.regs;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: both clamps, the wall boundary and full-scale force.
        items = '{mk_item(0, 0), mk_item(199, 32767), mk_item(200, -32768),
                  mk_item(330, 0), mk_item(331, 0), mk_item(349, 1), mk_item(350, -1),
                  mk_item(4095, 32767), mk_item(2048, -32768), mk_item(349, -32768),
                  mk_item(349, -32768), mk_item(331, 12345)};
        send_list(items);

        // Steepest ramp and largest gains: target saturates and the current
        // clips at both ends.
        program_regs(mk_regs(0, 0, 65535, 1023, 1023, 1023, 1023, 32767), 1'b1);
        items = '{mk_item(149, -32768), mk_item(149, -32768), mk_item(4095, -32768),
                  mk_item(0, 32767), mk_item(0, 32767), mk_item(0, 32767),
                  mk_item(0, -32768), mk_item(0, -32768)};
        send_list(items);

        // Wall start past the table end, zero gains and a zero current limit.
        program_regs(mk_regs(4095, 1023, 0, 0, 0, 0, 0, 0), 1'b0);
        items = '{mk_item(4095, 1234), mk_item(0, -5)};
        send_list(items);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            program_regs(random_regs(), phase % 3 == 0);
            if (phase == 2 || phase == 6) begin
                rx_hold = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                quiet = (n >= 40 && n < 70);
                if (n == 100) begin
                    pause_until_drained();
                end
                send_item(random_item());
            end
            quiet = 1'b0;
            pause_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.queued.size() > 0) begin
            sb.report($sformatf("%0d predicted results never arrived", sb.queued.size()));
        end
        $display("%0d ticks checked over %0d register settings", sb.checked, settings);
        $display("%0d ticks inside the wall, %0d with the current clipped",
                 sb.wall_count, sb.clip_count);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- haptic_wall_force_pd_controller_core.f -----
src/hwfpd_pkg.sv
src/hwfpd_ctrl.sv
src/hwfpd_datapath.sv
src/haptic_wall_force_pd_controller_core.sv
bench/haptic_wall_force_pd_controller_core_tb.sv
